/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Each one is sampled on clk and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

/* design/i2cbb_pkg.sv */
// ---------------------------------------------------------------------------
// i2cbb_pkg
// Types, codes and the command step table of the bit-banged I2C master.
// ---------------------------------------------------------------------------
package i2cbb_pkg;

	localparam int HOLD_W = 24;
	localparam int LINE_W = 4;
	localparam int STEP_W = 5;
	localparam logic [7:0] MSB_MASK = 8'h80;

	// Configuration register indexes
	localparam logic [1:0] REG_HOLD = 2'd0;
	localparam logic [1:0] REG_SDA  = 2'd1;
	localparam logic [1:0] REG_SCL  = 2'd2;

	localparam logic [HOLD_W-1:0] HOLD_RST = 24'd1000;
	localparam logic [LINE_W-1:0] SDA_RST  = 4'd0;
	localparam logic [LINE_W-1:0] SCL_RST  = 4'd1;

	typedef enum logic [2:0] {
		OP_INIT    = 3'd0,
		OP_START   = 3'd1,
		OP_RESTART = 3'd2,
		OP_STOP    = 3'd3,
		OP_ACK     = 3'd4,
		OP_NAK     = 3'd5,
		OP_SEND    = 3'd6,
		OP_READ    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		LVL_LOW,
		LVL_HIGH,
		LVL_DATA
	} lvl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_HOLD
	} state_t;

	// One line write of a command
	typedef struct packed {
		logic is_scl;
		lvl_t level;
		logic last;
		logic shift;
		logic sample;
	} step_t;

	typedef struct packed {
		logic  load;
		logic  emit;
		logic  hold_run;
		step_t step;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic out_free;
		logic hold_done;
	} dp_sts_t;

	// Decode the line write at position step of a command. phase counts
	// 0..2 inside a send bit group: SCL low, SDA data, SCL high.
	function automatic step_t step_decode(input op_t op, input logic [STEP_W-1:0] step,
		input logic [1:0] phase);
		step_t s;
		s.is_scl = 1'b1;
		s.level  = LVL_LOW;
		s.last   = 1'b0;
		s.shift  = 1'b0;
		s.sample = 1'b0;
		unique case (op)
			OP_INIT: begin
				s.is_scl = (step == 5'd1);
				s.level  = LVL_HIGH;
				s.last   = (step == 5'd1);
			end
			OP_START: begin
				s.last = (step == 5'd2);
				unique case (step)
					5'd0: s.level = LVL_HIGH;
					5'd1: s.is_scl = 1'b0;
					default: s.level = LVL_LOW;
				endcase
			end
			OP_RESTART: begin
				s.last = (step == 5'd3);
				unique case (step)
					5'd0: s.level = LVL_LOW;
					5'd1: begin
						s.is_scl = 1'b0;
						s.level  = LVL_HIGH;
					end
					5'd2: s.level = LVL_HIGH;
					default: s.is_scl = 1'b0;
				endcase
			end
			OP_STOP: begin
				s.last = (step == 5'd3);
				unique case (step)
					5'd0: s.level = LVL_LOW;
					5'd1: s.is_scl = 1'b0;
					5'd2: s.level = LVL_HIGH;
					default: begin
						s.is_scl = 1'b0;
						s.level  = LVL_HIGH;
					end
				endcase
			end
			OP_ACK: begin
				s.last = (step == 5'd3);
				unique case (step)
					5'd0: s.is_scl = 1'b0;
					5'd1: s.level = LVL_HIGH;
					5'd2: s.level = LVL_LOW;
					default: begin
						s.is_scl = 1'b0;
						s.level  = LVL_HIGH;
					end
				endcase
			end
			OP_NAK: begin
				s.last = (step == 5'd2);
				unique case (step)
					5'd0: begin
						s.is_scl = 1'b0;
						s.level  = LVL_HIGH;
					end
					5'd1: s.level = LVL_HIGH;
					default: s.level = LVL_LOW;
				endcase
			end
			OP_SEND: begin
				if (step < 5'd24) begin
					unique case (phase)
						2'd1: begin
							s.is_scl = 1'b0;
							s.level  = LVL_DATA;
							s.shift  = 1'b1;
						end
						2'd2: s.level = LVL_HIGH;
						default: s.level = LVL_LOW;
					endcase
				end else if (step == 5'd24) begin
					s.level = LVL_LOW;
				end else begin
					s.is_scl = 1'b0;
					s.level  = LVL_HIGH;
					s.last   = 1'b1;
				end
			end
			OP_READ: begin
				if (step < 5'd16) begin
					s.level  = step[0] ? LVL_HIGH : LVL_LOW;
					s.sample = step[0];
				end else if (step == 5'd16) begin
					s.level = LVL_LOW;
				end else begin
					s.is_scl = 1'b0;
					s.level  = LVL_HIGH;
					s.last   = 1'b1;
				end
			end
		endcase
		return s;
	endfunction

endpackage

/* design/i2cbb_ctrl.sv */
// ---------------------------------------------------------------------------
// i2cbb_ctrl
// Command sequencer: walks the line writes of a command and paces them
// with the hold counter of the datapath.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cbb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2cbb_pkg::dp_sts_t    sts,
	output i2cbb_pkg::ctrl_cmd_t  cmd
);

	i2cbb_pkg::state_t                 state_q, state_d;
	logic [i2cbb_pkg::STEP_W-1:0]      step_q, step_d;
	logic [1:0]                        phase_q, phase_d;
	logic                              last_q, last_d;
	i2cbb_pkg::step_t                  dec;

	assign dec = i2cbb_pkg::step_decode(sts.op, step_q, phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cbb_pkg::ST_IDLE;
			step_q  <= '0;
			phase_q <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			phase_q <= phase_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		phase_d      = phase_q;
		last_d       = last_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.hold_run = 1'b0;
		cmd.step     = dec;
		unique case (state_q)
			i2cbb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = '0;
					phase_d  = '0;
					state_d  = i2cbb_pkg::ST_EMIT;
				end
			end
			i2cbb_pkg::ST_EMIT: begin
				// wait for room in the output register
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					last_d   = dec.last;
					state_d  = i2cbb_pkg::ST_HOLD;
				end
			end
			i2cbb_pkg::ST_HOLD: begin
				cmd.hold_run = 1'b1;
				if (sts.hold_done) begin
					if (last_q) begin
						state_d = i2cbb_pkg::ST_IDLE;
					end else begin
						step_d  = step_q + 5'd1;
						phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
						state_d = i2cbb_pkg::ST_EMIT;
					end
				end
			end
			default: state_d = i2cbb_pkg::ST_IDLE;
		endcase
	end

	`ASSERT_NEVER(a_step_range, state_q != i2cbb_pkg::ST_IDLE && step_q > 5'd25, "step beyond the longest command")
	`ASSERT_CLK(a_load_start, cmd.load |=> state_q == i2cbb_pkg::ST_EMIT && step_q == '0, "command did not start at its first write")
	`ASSERT_CLK(a_emit_hold, cmd.emit |=> state_q == i2cbb_pkg::ST_HOLD, "line write not followed by a hold")

endmodule

/* design/i2cbb_dp.sv */
// ---------------------------------------------------------------------------
// i2cbb_dp
// Datapath: configuration registers, send shifter, read assembler, hold
// counter and the output register for line writes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cbb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [i2cbb_pkg::HOLD_W-1:0]  cfg_data,
	input  logic [2:0]                    op,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    sda_samples,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2cbb_pkg::LINE_W-1:0]  line_index,
	output logic                          line_level,
	output logic                          is_last,
	output logic [7:0]                    read_data,
	input  i2cbb_pkg::ctrl_cmd_t          cmd,
	output i2cbb_pkg::dp_sts_t            sts
);

	logic [i2cbb_pkg::HOLD_W-1:0]  hold_cycles_q;
	logic [i2cbb_pkg::LINE_W-1:0]  sda_idx_q;
	logic [i2cbb_pkg::LINE_W-1:0]  scl_idx_q;
	logic [i2cbb_pkg::HOLD_W-1:0]  hold_q;
	logic [i2cbb_pkg::HOLD_W-1:0]  hold_eff;
	i2cbb_pkg::op_t                op_q;
	logic [7:0]                    shift_q;
	logic [7:0]                    samp_q;
	logic [7:0]                    accum_q;
	logic                          out_valid_q;
	logic [i2cbb_pkg::LINE_W-1:0]  line_q;
	logic                          level_q;
	logic                          last_q;
	logic [7:0]                    rd_q;
	logic                          data_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles_q <= i2cbb_pkg::HOLD_RST;
			sda_idx_q     <= i2cbb_pkg::SDA_RST;
			scl_idx_q     <= i2cbb_pkg::SCL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cbb_pkg::REG_HOLD: hold_cycles_q <= cfg_data;
				i2cbb_pkg::REG_SDA:  sda_idx_q <= cfg_data[i2cbb_pkg::LINE_W-1:0];
				i2cbb_pkg::REG_SCL:  scl_idx_q <= cfg_data[i2cbb_pkg::LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero hold setting is taken as one
	assign hold_eff = (hold_cycles_q == '0) ? 24'd1 : hold_cycles_q;
	assign data_bit = |(shift_q & i2cbb_pkg::MSB_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				hold_q <= hold_eff;
			end else if (cmd.hold_run && hold_q != '0) begin
				hold_q <= hold_q - 24'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= i2cbb_pkg::OP_INIT;
		end else if (cmd.load) begin
			op_q <= i2cbb_pkg::op_t'(op);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= data_byte;
			samp_q  <= sda_samples;
			accum_q <= '0;
		end else if (cmd.emit) begin
			if (cmd.step.shift) begin
				shift_q <= {shift_q[6:0], 1'b0};
			end
			if (cmd.step.sample) begin
				accum_q <= {accum_q[6:0], samp_q[7]};
				samp_q  <= {samp_q[6:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			line_q <= cmd.step.is_scl ? scl_idx_q : sda_idx_q;
			unique case (cmd.step.level)
				i2cbb_pkg::LVL_HIGH: level_q <= 1'b1;
				i2cbb_pkg::LVL_DATA: level_q <= data_bit;
				default:             level_q <= 1'b0;
			endcase
			last_q <= cmd.step.last;
			rd_q   <= (cmd.step.last && op_q == i2cbb_pkg::OP_READ) ? accum_q : 8'd0;
		end
	end

	assign sts.op        = op_q;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.hold_done = (hold_q == 24'd1) || (hold_q == '0);

	assign out_valid  = out_valid_q;
	assign line_index = line_q;
	assign line_level = level_q;
	assign is_last    = last_q;
	assign read_data  = rd_q;

	`ASSERT_CLK(a_rd_last_only, out_valid_q && !last_q |-> rd_q == 8'd0, "read byte too early")

endmodule

/* design/i2c_bitbang_master.sv */
// ---------------------------------------------------------------------------
// i2c_bitbang_master
// Bit-banged I2C master: expands bus commands into timed SCL/SDA writes.
// ---------------------------------------------------------------------------
// Each accepted command (init, start, restart, stop, ack, nak, send byte,
// read byte) comes out as a run of 2 to 26 line writes, one transfer each,
// in bus order, with is_last set on the final one and the assembled byte on
// read_data at the end of a read. After every write the line level is held
// for the time set in the REG_HOLD register (a value of 0 counts as 1) by
// a 24-bit down counter, and a write waits while the output side stalls.
// The next command is taken once the hold after the last write has run
// out; the last write may still be waiting at the output then. Write
// configuration only while no command is in flight.
// ---------------------------------------------------------------------------
module i2c_bitbang_master (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [i2cbb_pkg::HOLD_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    op,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    sda_samples,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2cbb_pkg::LINE_W-1:0]  line_index,
	output logic                          line_level,
	output logic                          is_last,
	output logic [7:0]                    read_data
);

	i2cbb_pkg::ctrl_cmd_t  cmd;
	i2cbb_pkg::dp_sts_t    sts;

	i2cbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2cbb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.data_byte   (data_byte),
		.sda_samples (sda_samples),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.line_index  (line_index),
		.line_level  (line_level),
		.is_last     (is_last),
		.read_data   (read_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
